FILE: rtl/assert_macros.svh
// Assertion macros for the RTL of the rolling z-score signal block (used by rzrs_ctrl).
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RZ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("rzrs assertion failed");
`define RZ_ASSERT_IMP(lbl, pre, post) `RZ_ASSERT(lbl, (pre) |-> (post))
`else
`define RZ_ASSERT(lbl, prop)
`define RZ_ASSERT_IMP(lbl, pre, post)
`endif
`endif

FILE: rtl/rzrs_pkg.sv
// Types and constants of the rolling z-score signal block.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package rzrs_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_CNT_W  = 7;

    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_LENGTH   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_WARMUP_COUNT    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_UPPER_THRESHOLD = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_LOWER_THRESHOLD = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_EXIT_LEVEL      = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_ORDER_QUANTITY  = 3'd5;

    localparam logic [6:0]         RST_WINDOW_LENGTH   = 7'd60;
    localparam logic [6:0]         RST_WARMUP_COUNT    = 7'd20;
    localparam logic signed [15:0] RST_UPPER_THRESHOLD = 16'sd512;
    localparam logic signed [15:0] RST_LOWER_THRESHOLD = -16'sd512;
    localparam logic [14:0]        RST_EXIT_LEVEL      = 15'd128;
    localparam logic [15:0]        RST_ORDER_QUANTITY  = 16'd1;

    // Fractional bits of the squared z-score scale (256 squared).
    localparam int Z_SHIFT = 16;
    // Quotient bits kept by the divider; 2^30 equals 32768 squared.
    localparam int QUO_W   = 30;
    localparam int ROOT_W  = 15;
    localparam int STEP_W  = 5;
    localparam int DIV_STEPS  = QUO_W;
    localparam int SQRT_STEPS = ROOT_W;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_SHORT = 2'd1,
        ACT_LONG  = 2'd2,
        ACT_EXIT  = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQR,
        OP_ACC,
        OP_MUL1,
        OP_MUL2,
        OP_MUL3,
        OP_MUL4,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_SQRT_STEP,
        OP_PUBLISH,
        OP_PUBLISH_NONE
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQR,
        ST_ACC,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_MUL4,
        ST_DIV_INIT,
        ST_DIV,
        ST_SQRT,
        ST_PUBLISH
    } t_state;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic warm_ok;
        logic var_zero;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: rtl/rzrs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
module rzrs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old contents when the same address is written.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/rzrs_ctrl.sv
// Sequencer of the rolling z-score signal block.
// Uses rzrs_pkg and assert_macros.svh; drives rzrs_dp by commands.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rzrs_ctrl
    import rzrs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);
    t_state             r_state, n_state;
    logic [STEP_W-1:0]  r_cnt, n_cnt;
    logic               r_none, n_none;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_none  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_none  <= n_none;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_none     = r_none;
        o_cmd.op   = OP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_none   = 1'b0;
                    n_state  = ST_SQR;
                end
            end
            ST_SQR: begin
                o_cmd.op = OP_SQR;
                n_state  = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.op = OP_ACC;
                n_state  = ST_MUL1;
            end
            ST_MUL1: begin
                o_cmd.op = OP_MUL1;
                n_state  = ST_MUL2;
            end
            ST_MUL2: begin
                if (!i_stat.warm_ok) begin
                    n_none  = 1'b1;
                    n_state = ST_PUBLISH;
                end else begin
                    o_cmd.op = OP_MUL2;
                    n_state  = ST_MUL3;
                end
            end
            ST_MUL3: begin
                if (i_stat.var_zero) begin
                    n_none  = 1'b1;
                    n_state = ST_PUBLISH;
                end else begin
                    o_cmd.op = OP_MUL3;
                    n_state  = ST_MUL4;
                end
            end
            ST_MUL4: begin
                o_cmd.op = OP_MUL4;
                n_state  = ST_DIV_INIT;
            end
            ST_DIV_INIT: begin
                o_cmd.op = OP_DIV_INIT;
                n_cnt    = '0;
                n_state  = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.op = OP_DIV_STEP;
                if (r_cnt == STEP_W'(DIV_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_SQRT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_SQRT: begin
                o_cmd.op = OP_SQRT_STEP;
                if (r_cnt == STEP_W'(SQRT_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_PUBLISH;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_PUBLISH: begin
                if (i_stat.out_free) begin
                    o_cmd.op = r_none ? OP_PUBLISH_NONE : OP_PUBLISH;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `RZ_ASSERT(a_accept_to_sqr, (r_state == ST_IDLE && i_in_valid) |=> (r_state == ST_SQR))
    `RZ_ASSERT_IMP(a_div_count, r_state == ST_DIV, r_cnt < STEP_W'(DIV_STEPS))
    `RZ_ASSERT_IMP(a_pub_free, o_cmd.op == OP_PUBLISH || o_cmd.op == OP_PUBLISH_NONE, i_stat.out_free)
endmodule

FILE: rtl/rzrs_dp.sv
// Datapath of the rolling z-score signal block: sample ring, running sums,
// multiplies, divider, square root and decision. Uses rzrs_pkg and rzrs_ram.
`timescale 1ns / 1ps
module rzrs_dp
    import rzrs_pkg::*;
#(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_holding,
    input  logic                   i_legs_usable,
    input  t_dp_cmd                i_cmd,
    output t_dp_stat               o_stat,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [1:0]             o_action,
    output logic [15:0]            o_z_score,
    output logic [15:0]            o_quantity
);
    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int SLOT_W = $clog2(WINDOW_MAX);
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    localparam int SQ_W   = 2 * SAMPLE_BITS;
    localparam int Q_W    = SQ_W + CNT_W;
    localparam int D_W    = Q_W + CNT_W;
    localparam int A2_W   = 2 * SUM_W;
    localparam int R_W    = A2_W + CNT_W + Z_SHIFT;
    localparam int M_W    = D_W + CNT_W;
    localparam int DIV_W  = (R_W > M_W + QUO_W + 1) ? R_W : M_W + QUO_W + 1;
    localparam int CMP_W  = ((CNT_W > CFG_CNT_W) ? CNT_W : CFG_CNT_W) + 1;

    // Configuration registers.
    logic [CFG_CNT_W-1:0] r_window, r_warmup;
    logic signed [15:0]   r_upper, r_lower;
    logic [14:0]          r_exit;
    logic [15:0]          r_qty_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window  <= RST_WINDOW_LENGTH;
            r_warmup  <= RST_WARMUP_COUNT;
            r_upper   <= RST_UPPER_THRESHOLD;
            r_lower   <= RST_LOWER_THRESHOLD;
            r_exit    <= RST_EXIT_LEVEL;
            r_qty_cfg <= RST_ORDER_QUANTITY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_WINDOW_LENGTH:   r_window  <= i_cfg_data[CFG_CNT_W-1:0];
                CFG_WARMUP_COUNT:    r_warmup  <= i_cfg_data[CFG_CNT_W-1:0];
                CFG_UPPER_THRESHOLD: r_upper   <= signed'(i_cfg_data);
                CFG_LOWER_THRESHOLD: r_lower   <= signed'(i_cfg_data);
                CFG_EXIT_LEVEL:      r_exit    <= i_cfg_data[14:0];
                CFG_ORDER_QUANTITY:  r_qty_cfg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Window state.
    logic [CNT_W-1:0]  r_fill;
    logic [SLOT_W-1:0] r_slot;
    logic [SUM_W-1:0]  r_sum;
    logic [Q_W-1:0]    r_sqsum;

    // Item registers.
    logic [SAMPLE_BITS-1:0] r_x, r_old;
    logic                   r_hold, r_legs;
    logic [SQ_W-1:0]        r_xx, r_oo;
    logic [D_W-1:0]         r_nq, r_ss, r_d;
    logic [SUM_W-1:0]       r_nx, r_a;
    logic                   r_neg;
    logic [A2_W-1:0]        r_a2;
    logic [R_W-1:0]         r_r;
    logic [M_W-1:0]         r_m;
    logic [DIV_W-1:0]       r_rem, r_dm;
    logic                   r_sat;
    logic [QUO_W-1:0]       r_q;
    logic [ROOT_W-1:0]      r_root, r_bit;

    // Output register.
    logic        r_ov;
    t_action     r_action;
    logic [15:0] r_z, r_qty;

    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic [SLOT_W-1:0]      old_idx;
    logic [CNT_W:0]         slot_e, fill_e, idx_e;
    logic [CMP_W-1:0]       win_c, need_c, fill1_c;
    logic [DIV_W-1:0]       r_ext, m_sat;
    logic [ROOT_W-1:0]      trial;
    logic [2*ROOT_W-1:0]    trial_sq;
    logic [15:0]            k_mag, mag;
    logic signed [15:0]     z_val;
    t_action                act;
    logic [15:0]            qty;

    // Oldest live sample sits fill_count slots behind the write slot.
    always_comb begin
        slot_e = (CNT_W + 1)'(r_slot);
        fill_e = (CNT_W + 1)'(r_fill);
        if (slot_e >= fill_e) begin
            idx_e = slot_e - fill_e;
        end else begin
            idx_e = slot_e + (CNT_W + 1)'(WINDOW_MAX) - fill_e;
        end
        old_idx = idx_e[SLOT_W-1:0];
    end

    rzrs_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.op == OP_LOAD),
        .i_waddr (r_slot),
        .i_wdata (i_sample),
        .i_raddr (old_idx),
        .o_rdata (ram_rdata)
    );

    // A window length of zero acts as one; lengths past the ring are clamped.
    always_comb begin
        if (r_window == '0) begin
            win_c = CMP_W'(1);
        end else if (CMP_W'(r_window) > CMP_W'(WINDOW_MAX)) begin
            win_c = CMP_W'(WINDOW_MAX);
        end else begin
            win_c = CMP_W'(r_window);
        end
        need_c  = (r_warmup > CFG_CNT_W'(2)) ? CMP_W'(r_warmup) : CMP_W'(2);
        fill1_c = CMP_W'(r_fill) + CMP_W'(1);
    end

    always_comb begin
        r_ext    = DIV_W'(r_r);
        m_sat    = DIV_W'(r_m) << QUO_W;
        trial    = r_root | r_bit;
        trial_sq = (2 * ROOT_W)'(trial) * (2 * ROOT_W)'(trial);
    end

    // Final z-score and decision.
    always_comb begin
        k_mag = r_sat ? 16'h8000 : 16'(r_root);
        if (r_neg) begin
            z_val = signed'(16'(16'd0 - k_mag));
            mag   = k_mag;
        end else begin
            z_val = k_mag[15] ? 16'sh7FFF : signed'(k_mag);
            mag   = 16'(z_val);
        end
        act = ACT_NONE;
        qty = '0;
        if (!r_hold) begin
            if (r_legs) begin
                if (z_val >= r_upper) begin
                    act = ACT_SHORT;
                    qty = r_qty_cfg;
                end else if (z_val <= r_lower) begin
                    act = ACT_LONG;
                    qty = r_qty_cfg;
                end
            end
        end else if (mag <= 16'(r_exit)) begin
            act = ACT_EXIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_slot  <= '0;
            r_sum   <= '0;
            r_sqsum <= '0;
        end else if (i_cmd.op == OP_ACC) begin
            r_slot <= (r_slot == SLOT_W'(WINDOW_MAX - 1)) ? '0 : r_slot + 1'b1;
            if (fill1_c > win_c) begin
                r_sum   <= r_sum + SUM_W'(r_x) - SUM_W'(r_old);
                r_sqsum <= r_sqsum + Q_W'(r_xx) - Q_W'(r_oo);
            end else begin
                r_sum   <= r_sum + SUM_W'(r_x);
                r_sqsum <= r_sqsum + Q_W'(r_xx);
                r_fill  <= r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_x    <= i_sample;
                r_hold <= i_holding;
                r_legs <= i_legs_usable;
            end
            OP_SQR: begin
                r_old <= ram_rdata;
                r_xx  <= SQ_W'(r_x) * SQ_W'(r_x);
                r_oo  <= SQ_W'(ram_rdata) * SQ_W'(ram_rdata);
            end
            OP_MUL1: begin
                r_nq <= D_W'(r_fill) * D_W'(r_sqsum);
                r_ss <= D_W'(r_sum) * D_W'(r_sum);
                r_nx <= SUM_W'(r_fill) * SUM_W'(r_x);
            end
            OP_MUL2: begin
                r_d   <= r_nq - r_ss;
                r_neg <= r_nx < r_sum;
                r_a   <= (r_nx < r_sum) ? r_sum - r_nx : r_nx - r_sum;
            end
            OP_MUL3: begin
                r_a2 <= A2_W'(r_a) * A2_W'(r_a);
            end
            OP_MUL4: begin
                r_r <= (R_W'(r_a2) * R_W'(r_fill - 1'b1)) << Z_SHIFT;
                r_m <= M_W'(r_d) * M_W'(r_fill);
            end
            OP_DIV_INIT: begin
                r_rem  <= r_ext;
                r_dm   <= DIV_W'(r_m) << (QUO_W - 1);
                r_sat  <= r_ext >= m_sat;
                r_q    <= '0;
                r_root <= '0;
                r_bit  <= ROOT_W'(1) << (ROOT_W - 1);
            end
            OP_DIV_STEP: begin
                if (r_rem >= r_dm) begin
                    r_rem <= r_rem - r_dm;
                    r_q   <= {r_q[QUO_W-2:0], 1'b1};
                end else begin
                    r_q   <= {r_q[QUO_W-2:0], 1'b0};
                end
                r_dm <= r_dm >> 1;
            end
            OP_SQRT_STEP: begin
                if (trial_sq <= r_q) begin
                    r_root <= trial;
                end
                r_bit <= r_bit >> 1;
            end
            OP_PUBLISH: begin
                r_action <= act;
                r_z      <= 16'(z_val);
                r_qty    <= qty;
            end
            OP_PUBLISH_NONE: begin
                r_action <= ACT_NONE;
                r_z      <= '0;
                r_qty    <= '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.op == OP_PUBLISH || i_cmd.op == OP_PUBLISH_NONE) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_stat.warm_ok  = CMP_W'(r_fill) >= need_c;
    assign o_stat.var_zero = (r_d == '0);
    assign o_stat.out_free = !r_ov || i_out_ready;
    assign o_out_valid     = r_ov;
    assign o_action        = r_action;
    assign o_z_score       = r_z;
    assign o_quantity      = r_qty;
endmodule

FILE: rtl/rolling_zscore_reversion_signal.sv
// Top level of the rolling z-score mean-reversion signal block.
// Uses rzrs_pkg, rzrs_ctrl, rzrs_dp (with rzrs_ram inside).
//
//  Channel   Direction  Handshake                  Contents
//  s_axis    in         tvalid / tready            sample, holding, legs_usable
//  m_axis    out        tvalid / tready            action, z_score, quantity
//  config    in         i_cfg_we (no wait)         register index and value
//
// Each item passes from acceptance through the products, the 30-step
// restoring divider and the 15-step square root to a result in the output
// register. Items still warming up skip the divider and square root after
// the first products; items with zero variance skip them after the variance.
// The next item is accepted the cycle after a result is loaded, even if
// that result has not yet been taken. Reset is synchronous and active low;
// it clears the sums and counts and loads the configuration defaults.
// A stalled output holds the sequencer in publish until the result is taken.
`timescale 1ns / 1ps
module rolling_zscore_reversion_signal
    import rzrs_pkg::*;
#(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]             i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]             i_cfg_data,
    // Input items.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: sample, zero padded to whole bytes.
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_axis_tdata,
    // tuser: bit 0 holding, bit 1 legs_usable.
    input  logic [1:0]                        s_axis_tuser,
    // Result items.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: z_score in bits 15:0, quantity in bits 31:16.
    output logic [31:0]                       m_axis_tdata,
    // tuser: action.
    output logic [1:0]                        m_axis_tuser
);
    t_dp_cmd     cmd;
    t_dp_stat    stat;
    logic [15:0] z_score, quantity;

    // The sequencer steps the datapath through update, products, division,
    // square root and publish, one command per cycle unless a stalled output holds it.
    rzrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rzrs_dp #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_sample      (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_holding     (s_axis_tuser[0]),
        .i_legs_usable (s_axis_tuser[1]),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_action      (m_axis_tuser),
        .o_z_score     (z_score),
        .o_quantity    (quantity)
    );

    assign m_axis_tdata = {quantity, z_score};
endmodule
